>>> design/nearest_point_lookup_macros.svh
// Assertion macros for the nearest point lookup checker.
// Needs clk and rst_n in the scope of the user.
`ifndef NEAREST_POINT_LOOKUP_MACROS_SVH
`define NEAREST_POINT_LOOKUP_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define NPL_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nearest_point_lookup: check failed");

// Next-cycle implication, disabled in reset.
`define NPL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nearest_point_lookup: check failed");

`endif

>>> design/nplk_pkg.sv
// Shared types and constants for the nearest point lookup.
// No dependencies.
package nplk_pkg;

    localparam int MAX_ENTRIES = 256;
    localparam int COORD_WIDTH = 16;

    localparam int IDX_W  = $clog2(MAX_ENTRIES);
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int DIFF_W = COORD_WIDTH + 1;
    localparam int SQ_W   = 2 * COORD_WIDTH;
    localparam int SUM_W  = SQ_W + 2;
    // distance in whole units is isqrt(sum / 64)
    localparam int RAD_W  = SUM_W - 6;
    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 2;

    localparam int MODE_W  = 2;
    localparam int INDEX_W = 8;
    localparam int DIST_W  = 14;

    typedef enum logic [MODE_W-1:0] {
        MODE_CLEAR  = 2'd0,
        MODE_APPEND = 2'd1,
        MODE_QUERY  = 2'd2,
        MODE_UNUSED = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        CMD_CLEAR,
        CMD_APPEND,
        CMD_QUERY,
        CMD_NOP
    } cmd_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_WALK,
        BK_WAIT
    } back_state_t;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;

    typedef struct packed {
        logic   labelled;
        coord_t x;
        coord_t y;
        coord_t z;
    } entry_t;

    typedef struct packed {
        cmd_t   cmd;
        entry_t pt;
    } cmd_item_t;

    typedef struct packed {
        logic      valid;
        cmd_item_t item;
    } q_head_t;

    typedef struct packed {
        logic             last;
        logic             labelled;
        logic [IDX_W-1:0] idx;
    } tag_t;

endpackage

>>> design/nplk_front.sv
// Front end: takes transactions, classifies the mode, queues up to two commands.
// Depends on nplk_pkg.
module nplk_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [1:0]                  mode,
    input  logic signed [15:0]          coord_x,
    input  logic signed [15:0]          coord_y,
    input  logic signed [15:0]          coord_z,
    input  logic                        has_label,
    output logic                        busy,
    input  logic                        pop,
    output nplk_pkg::q_head_t           head
);

    nplk_pkg::cmd_item_t fifo_mem [2];
    logic                wr_ptr_reg, wr_ptr_next;
    logic                rd_ptr_reg, rd_ptr_next;
    logic [1:0]          count_reg, count_next;
    logic                push;
    logic                do_pop;
    nplk_pkg::cmd_item_t in_item;

    always_comb
    begin
        case (nplk_pkg::mode_t'(mode))
            nplk_pkg::MODE_CLEAR:  in_item.cmd = nplk_pkg::CMD_CLEAR;
            nplk_pkg::MODE_APPEND: in_item.cmd = nplk_pkg::CMD_APPEND;
            nplk_pkg::MODE_QUERY:  in_item.cmd = nplk_pkg::CMD_QUERY;
            default:               in_item.cmd = nplk_pkg::CMD_NOP;
        endcase
        in_item.pt.labelled = has_label;
        in_item.pt.x = nplk_pkg::coord_t'(coord_x);
        in_item.pt.y = nplk_pkg::coord_t'(coord_y);
        in_item.pt.z = nplk_pkg::coord_t'(coord_z);
    end

    assign busy   = (count_reg == 2'd2);
    assign push   = start && !busy;
    assign do_pop = pop && (count_reg != 2'd0);

    assign head.valid = (count_reg != 2'd0);
    assign head.item  = fifo_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem[wr_ptr_reg] <= in_item;
        end
    end

endmodule

>>> design/nplk_dist_pipe.sv
// Distance pipeline: |d| per axis, squares, sum, then one isqrt digit per stage.
// Depends on nplk_pkg.
module nplk_dist_pipe (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  nplk_pkg::tag_t                in_tag,
    input  nplk_pkg::entry_t              in_pt,
    input  nplk_pkg::entry_t              q_pt,
    output logic                          res_valid,
    output nplk_pkg::tag_t                res_tag,
    output logic [nplk_pkg::ROOT_W-1:0]   res_dist
);

    function automatic logic [nplk_pkg::COORD_WIDTH-1:0] abs_diff(
        input nplk_pkg::coord_t a,
        input nplk_pkg::coord_t b
    );
        logic signed [nplk_pkg::DIFF_W-1:0] d;
        d = nplk_pkg::DIFF_W'(a) - nplk_pkg::DIFF_W'(b);
        return d[nplk_pkg::DIFF_W-1] ? nplk_pkg::COORD_WIDTH'(-d)
                                     : nplk_pkg::COORD_WIDTH'(d);
    endfunction

    // stage A: magnitudes
    logic [nplk_pkg::COORD_WIDTH-1:0] mx_reg, my_reg, mz_reg;
    logic                             va_reg;
    nplk_pkg::tag_t                   ta_reg;
    // stage B: squares
    logic [nplk_pkg::SQ_W-1:0]        sx_reg, sy_reg, sz_reg;
    logic                             vb_reg;
    nplk_pkg::tag_t                   tb_reg;
    logic [nplk_pkg::SUM_W-1:0]       sum;

    // isqrt chain; element 0 is the radicand stage
    logic [nplk_pkg::RAD_W-1:0]       rad_s  [nplk_pkg::ROOT_W+1];
    logic                             vld_s  [nplk_pkg::ROOT_W+1];
    nplk_pkg::tag_t                   tag_s  [nplk_pkg::ROOT_W+1];
    logic [nplk_pkg::REM_W-1:0]       rem_s  [1:nplk_pkg::ROOT_W];
    logic [nplk_pkg::ROOT_W-1:0]      root_s [1:nplk_pkg::ROOT_W];

    assign sum = nplk_pkg::SUM_W'(sx_reg) + nplk_pkg::SUM_W'(sy_reg)
               + nplk_pkg::SUM_W'(sz_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg   <= 1'b0;
            vb_reg   <= 1'b0;
            vld_s[0] <= 1'b0;
        end
        else
        begin
            va_reg   <= in_valid;
            vb_reg   <= va_reg;
            vld_s[0] <= vb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        mx_reg   <= abs_diff(in_pt.x, q_pt.x);
        my_reg   <= abs_diff(in_pt.y, q_pt.y);
        mz_reg   <= abs_diff(in_pt.z, q_pt.z);
        ta_reg   <= in_tag;
        sx_reg   <= mx_reg * mx_reg;
        sy_reg   <= my_reg * my_reg;
        sz_reg   <= mz_reg * mz_reg;
        tb_reg   <= ta_reg;
        rad_s[0] <= sum[nplk_pkg::SUM_W-1:6];
        tag_s[0] <= tb_reg;
    end

    for (genvar k = 0; k < nplk_pkg::ROOT_W; k++)
    begin : g_step
        logic [nplk_pkg::REM_W-1:0]  rem_in;
        logic [nplk_pkg::ROOT_W-1:0] root_in;
        logic [nplk_pkg::REM_W+1:0]  cat;
        logic [nplk_pkg::REM_W+1:0]  trial;
        logic                        ge;

        if (k == 0)
        begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
        end
        else
        begin : g_rest
            assign rem_in  = rem_s[k];
            assign root_in = root_s[k];
        end

        assign cat   = {rem_in, rad_s[k][nplk_pkg::RAD_W-1 -: 2]};
        assign trial = (nplk_pkg::REM_W + 2)'({root_in, 2'b01});
        assign ge    = (cat >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_s[k+1] <= 1'b0;
            end
            else
            begin
                vld_s[k+1] <= vld_s[k];
            end
        end

        always_ff @(posedge clk)
        begin
            rad_s[k+1]  <= rad_s[k] << 2;
            rem_s[k+1]  <= ge ? nplk_pkg::REM_W'(cat - trial) : nplk_pkg::REM_W'(cat);
            root_s[k+1] <= {root_in[nplk_pkg::ROOT_W-2:0], ge};
            tag_s[k+1]  <= tag_s[k];
        end
    end

    assign res_valid = vld_s[nplk_pkg::ROOT_W];
    assign res_tag   = tag_s[nplk_pkg::ROOT_W];
    assign res_dist  = root_s[nplk_pkg::ROOT_W];

endmodule

>>> design/nplk_back.sv
// Back end: point table, command sequencer, nearest-entry tracking, result register.
// Depends on nplk_pkg; feeds nplk_dist_pipe.
module nplk_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  nplk_pkg::q_head_t             head,
    output logic                          pop,
    output logic                          walk_valid,
    output nplk_pkg::tag_t                walk_tag,
    output nplk_pkg::entry_t              walk_pt,
    output nplk_pkg::entry_t              walk_q,
    input  logic                          res_valid,
    input  nplk_pkg::tag_t                res_tag,
    input  logic [nplk_pkg::ROOT_W-1:0]   res_dist,
    output logic                          done,
    output logic                          status,
    output logic                          found,
    output logic [7:0]                    best_index,
    output logic [13:0]                   best_distance
);

    nplk_pkg::entry_t            point_table [nplk_pkg::MAX_ENTRIES];

    nplk_pkg::back_state_t       state_reg, state_next;
    logic [nplk_pkg::CNT_W-1:0]  count_reg, count_next;
    logic [nplk_pkg::IDX_W-1:0]  addr_reg, addr_next;
    nplk_pkg::entry_t            qpt_reg, qpt_next;
    logic                        hit_reg, hit_next;
    logic [nplk_pkg::ROOT_W-1:0] best_reg, best_next;
    logic [nplk_pkg::IDX_W-1:0]  bidx_reg, bidx_next;

    nplk_pkg::entry_t            rd_data_reg;
    logic                        rd_vld_reg;
    logic                        rd_last_reg;
    logic [nplk_pkg::IDX_W-1:0]  rd_idx_reg;
    logic                        rd_en;
    logic                        wr_en;

    logic                        done_reg, done_next;
    logic                        status_reg, status_next;
    logic                        found_reg, found_next;
    logic [7:0]                  index_reg, index_next;
    logic [13:0]                 dist_reg, dist_next;
    logic                        take;

    assign walk_valid        = rd_vld_reg;
    assign walk_tag.last     = rd_last_reg;
    assign walk_tag.labelled = rd_data_reg.labelled;
    assign walk_tag.idx      = rd_idx_reg;
    assign walk_pt           = rd_data_reg;
    assign walk_q            = qpt_reg;

    assign done          = done_reg;
    assign status        = status_reg;
    assign found         = found_reg;
    assign best_index    = index_reg;
    assign best_distance = dist_reg;

    // strictly smaller only: walking newest first, so the newer entry keeps a tie
    assign take = res_valid && res_tag.labelled && (!hit_reg || (res_dist < best_reg));

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        addr_next   = addr_reg;
        qpt_next    = qpt_reg;
        hit_next    = hit_reg;
        best_next   = best_reg;
        bidx_next   = bidx_reg;
        pop         = 1'b0;
        rd_en       = 1'b0;
        wr_en       = 1'b0;
        done_next   = 1'b0;
        status_next = 1'b0;
        found_next  = 1'b0;
        index_next  = '0;
        dist_next   = '0;

        if (take)
        begin
            hit_next  = 1'b1;
            best_next = res_dist;
            bidx_next = res_tag.idx;
        end

        case (state_reg)
            nplk_pkg::BK_IDLE:
            begin
                if (head.valid)
                begin
                    pop = 1'b1;
                    case (head.item.cmd)
                        nplk_pkg::CMD_CLEAR:
                        begin
                            count_next = '0;
                            done_next  = 1'b1;
                        end
                        nplk_pkg::CMD_APPEND:
                        begin
                            done_next = 1'b1;
                            if (count_reg == nplk_pkg::CNT_W'(nplk_pkg::MAX_ENTRIES))
                            begin
                                status_next = 1'b1;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        nplk_pkg::CMD_QUERY:
                        begin
                            hit_next  = 1'b0;
                            best_next = '0;
                            bidx_next = '0;
                            qpt_next  = head.item.pt;
                            if (count_reg == '0)
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                addr_next  = nplk_pkg::IDX_W'(count_reg - 1'b1);
                                state_next = nplk_pkg::BK_WALK;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            nplk_pkg::BK_WALK:
            begin
                rd_en     = 1'b1;
                addr_next = addr_reg - 1'b1;
                if (addr_reg == '0)
                begin
                    state_next = nplk_pkg::BK_WAIT;
                end
            end
            nplk_pkg::BK_WAIT:
            begin
                if (res_valid && res_tag.last)
                begin
                    done_next  = 1'b1;
                    found_next = hit_next;
                    index_next = 8'(bidx_next);
                    dist_next  = 14'(best_next);
                    state_next = nplk_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = nplk_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= nplk_pkg::BK_IDLE;
            count_reg  <= '0;
            rd_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            rd_vld_reg <= rd_en;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg   <= addr_next;
        qpt_reg    <= qpt_next;
        hit_reg    <= hit_next;
        best_reg   <= best_next;
        bidx_reg   <= bidx_next;
        status_reg <= status_next;
        found_reg  <= found_next;
        index_reg  <= index_next;
        dist_reg   <= dist_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            point_table[count_reg[nplk_pkg::IDX_W-1:0]] <= head.item.pt;
        end
        if (rd_en)
        begin
            rd_data_reg <= point_table[addr_reg];
            rd_idx_reg  <= addr_reg;
            rd_last_reg <= (addr_reg == '0);
        end
    end

endmodule

>>> design/nearest_point_lookup.sv
// Nearest point lookup: clear, append or query (one table read per cycle into the distance
// pipeline for each of the N stored entries; ROOT_W = 14).
// A two-deep command queue accepts transactions while the back end works; throughput is
// one command per back-end run. Reset empties the table; table contents are not cleared.
// Depends on nplk_pkg, nplk_front, nplk_dist_pipe, nplk_back.
module nearest_point_lookup (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           mode,
    input  logic signed [15:0]   coord_x,
    input  logic signed [15:0]   coord_y,
    input  logic signed [15:0]   coord_z,
    input  logic                 has_label,
    output logic                 done,
    output logic                 status,
    output logic                 found,
    output logic [7:0]           best_index,
    output logic [13:0]          best_distance
);

    // queue head and pop between front and back end
    nplk_pkg::q_head_t           head;
    logic                        pop;

    // back end to distance pipeline: one table entry per cycle while walking
    logic                        walk_valid;
    nplk_pkg::tag_t              walk_tag;
    nplk_pkg::entry_t            walk_pt;
    nplk_pkg::entry_t            walk_q;

    // pipeline results, in walk order, newest entry first
    logic                        res_valid;
    nplk_pkg::tag_t              res_tag;
    logic [nplk_pkg::ROOT_W-1:0] res_dist;

    // Front: classifies the mode and holds up to two transactions.
    nplk_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .mode      (mode),
        .coord_x   (coord_x),
        .coord_y   (coord_y),
        .coord_z   (coord_z),
        .has_label (has_label),
        .busy      (busy),
        .pop       (pop),
        .head      (head)
    );

    // Back: table, sequencing and the result register (strobed for one cycle).
    nplk_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .pop           (pop),
        .walk_valid    (walk_valid),
        .walk_tag      (walk_tag),
        .walk_pt       (walk_pt),
        .walk_q        (walk_q),
        .res_valid     (res_valid),
        .res_tag       (res_tag),
        .res_dist      (res_dist),
        .done          (done),
        .status        (status),
        .found         (found),
        .best_index    (best_index),
        .best_distance (best_distance)
    );

    // Whole-unit distance: floor(isqrt(sum of squares / 64)), one root bit per stage.
    nplk_dist_pipe u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (walk_valid),
        .in_tag    (walk_tag),
        .in_pt     (walk_pt),
        .q_pt      (walk_q),
        .res_valid (res_valid),
        .res_tag   (res_tag),
        .res_dist  (res_dist)
    );

endmodule

>>> design/nplk_checker.sv
// Port-level checks for nearest_point_lookup, bound to the top level.
// Depends on nearest_point_lookup_macros.svh.
`include "nearest_point_lookup_macros.svh"

module nplk_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic        status,
    input logic        found,
    input logic [7:0]  best_index,
    input logic [13:0] best_distance
);

    // a miss reports a zero index and distance
    `NPL_ASSERT_NOW(a_miss_zero, done && !found, (best_index == 8'd0) && (best_distance == 14'd0))

    // a refused append is never a query hit
    `NPL_ASSERT_NOW(a_full_no_hit, done && status, !found)

    // busy only follows an accepted transaction
    `NPL_ASSERT_NEXT(a_busy_cause, !busy && !start, !busy)

endmodule

bind nearest_point_lookup nplk_checker u_nplk_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .done          (done),
    .status        (status),
    .found         (found),
    .best_index    (best_index),
    .best_distance (best_distance)
);

>>> tb/sv/nearest_point_lookup_checker.sv
// Checker for the nearest point lookup: watches accepted commands and result strobes,
// predicts each result from its own copy of the point table and compares. Needs nplk_pkg.
module nearest_point_lookup_checker
    import nplk_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [1:0]         mode,
    input  logic signed [15:0] coord_x,
    input  logic signed [15:0] coord_y,
    input  logic signed [15:0] coord_z,
    input  logic               has_label,
    input  logic               done,
    input  logic               status,
    input  logic               found,
    input  logic [7:0]         best_index,
    input  logic [13:0]        best_distance,
    output int                 fail_count,
    output int                 pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        status;
        logic        found;
        logic [7:0]  index;
        logic [13:0] distance;
    } lookup_result_t;

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic               labelled;
    } stored_point_t;

    stored_point_t  points [MAX_ENTRIES];
    int             stored;
    lookup_result_t expected_q [$];
    int             result_count;

    function automatic longint unsigned sq_dist(logic signed [15:0] a, logic signed [15:0] b);
        longint d;
        d = longint'(a) - longint'(b);
        return longint'(d * d);
    endfunction

    function automatic longint unsigned isqrt(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n)
            b >>= 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    // Update the table copy and work out the result of one command.
    function automatic lookup_result_t predict_lookup(logic [1:0] m, logic signed [15:0] x,
                                                       logic signed [15:0] y,
                                                       logic signed [15:0] z, logic lab);
        lookup_result_t  r;
        longint unsigned d, best;
        r = '0;
        best = 0;
        case (m)
            MODE_CLEAR:  stored = 0;
            MODE_APPEND:
            begin
                if (stored >= MAX_ENTRIES)
                    r.status = 1'b1;
                else
                begin
                    points[stored] = '{x, y, z, lab};
                    stored++;
                end
            end
            MODE_QUERY:
            begin
                // newest first; strict compare keeps the newer entry on a tie
                for (int i = stored - 1; i >= 0; i--)
                begin
                    if (points[i].labelled)
                    begin
                        d = isqrt(sq_dist(points[i].x, x) + sq_dist(points[i].y, y)
                                  + sq_dist(points[i].z, z)) >> 3;
                        if (!r.found || d < best)
                        begin
                            r.found = 1'b1;
                            best    = d;
                            r.index = i[7:0];
                        end
                    end
                end
                r.distance = best[13:0];
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch on result %0d: %s got %0d expected %0d", result_count, what, got,
                 want);
        fail_count++;
    endtask

    initial
    begin
        fail_count   = 0;
        stored       = 0;
        result_count = 0;
        pending      = 0;
    end

    always @(posedge clk)
    begin
        lookup_result_t want;
        if (rst_n)
        begin
            if (start && !busy)
                expected_q.push_back(predict_lookup(mode, coord_x, coord_y, coord_z,
                                                    has_label));
            if (done)
            begin
                if (expected_q.size() == 0)
                    report_mismatch("unexpected strobe", 1, 0);
                else
                begin
                    want = expected_q.pop_front();
                    if (status !== want.status)
                        report_mismatch("status", status, want.status);
                    if (found !== want.found)
                        report_mismatch("found", found, want.found);
                    if (best_index !== want.index)
                        report_mismatch("best_index", best_index, want.index);
                    if (best_distance !== want.distance)
                        report_mismatch("best_distance", best_distance, want.distance);
                end
                result_count++;
            end
            pending = expected_q.size();
        end
    end
endmodule

>>> tb/sv/nearest_point_lookup_tb.sv
// Top of the nearest point lookup testbench: clock, reset, command stimulus and verdict.
// Depends on nplk_pkg, nearest_point_lookup and nearest_point_lookup_checker.
module nearest_point_lookup_tb;
    import nplk_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         mode;
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;
    logic signed [15:0] coord_z;
    logic               has_label;
    logic               done;
    logic               status;
    logic               found;
    logic [7:0]         best_index;
    logic [13:0]        best_distance;
    int                 fail_count;
    int                 pending;
    int                 n_query;
    int                 n_append;

    nearest_point_lookup u_dut (.*);

    nearest_point_lookup_checker u_chk (.*);

    initial
    begin
        clk = 1'b0;
        forever
            #1 clk = ~clk;
    end

    // Hold one command on the ports until the transaction is taken.
    task automatic issue(mode_t m, logic signed [15:0] x, logic signed [15:0] y,
                         logic signed [15:0] z, logic lab);
        start     <= 1'b1;
        mode      <= m;
        coord_x   <= x;
        coord_y   <= y;
        coord_z   <= z;
        has_label <= lab;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (m == MODE_QUERY)
            n_query++;
        else if (m == MODE_APPEND)
            n_append++;
    endtask

    // Random gap, usually none or short, now and then long; start drops only if a gap follows.
    task automatic sender_gap();
        int g;
        g = ($urandom_range(0, 9) < 6) ? 0 :
            ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(20, 400);
        if (g > 0)
        begin
            start <= 1'b0;
            repeat (g)
                @(posedge clk);
        end
    endtask

    function automatic logic signed [15:0] rand_coord();
        case ($urandom_range(0, 5))
            0:       return 16'sh7fff;
            1:       return -16'sh8000;
            2:       return 16'($urandom);
            default: return $signed(16'($urandom_range(0, 800))) - 16'sd400;
        endcase
    endfunction

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int m;
        start     <= 1'b0;
        mode      <= MODE_CLEAR;
        coord_x   <= '0;
        coord_y   <= '0;
        coord_z   <= '0;
        has_label <= 1'b0;
        n_query   = 0;
        n_append  = 0;
        rst_n     = 1'b0;
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty query, unlabelled only, extremes, ties, unused mode, clear.
        issue(MODE_QUERY, 0, 0, 0, 0);
        issue(MODE_APPEND, 5, 5, 5, 0);
        issue(MODE_QUERY, 5, 5, 5, 0);
        issue(MODE_APPEND, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1);
        issue(MODE_APPEND, -16'sh8000, -16'sh8000, -16'sh8000, 1);
        issue(MODE_QUERY, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1);
        issue(MODE_QUERY, -16'sh8000, -16'sh8000, -16'sh8000, 0);
        issue(MODE_QUERY, 0, 0, 0, 0);
        issue(MODE_QUERY, -16'sh8000, 16'sh7fff, -16'sh8000, 0);
        issue(MODE_APPEND, 8, 0, 0, 1);
        issue(MODE_APPEND, -8, 0, 0, 1);
        issue(MODE_QUERY, 0, 0, 0, 0);
        issue(MODE_QUERY, 3, 0, 0, 0);
        issue(MODE_UNUSED, 16'sh7fff, -16'sh8000, 1, 1);
        issue(MODE_CLEAR, -1, -1, -1, 1);
        issue(MODE_QUERY, 0, 0, 0, 0);

        // Fill the table, then refused appends and a full-depth query.
        for (int i = 0; i < MAX_ENTRIES; i++)
            issue(MODE_APPEND, rand_coord(), rand_coord(), rand_coord(), 1'($urandom));
        issue(MODE_APPEND, 1, 2, 3, 1);
        issue(MODE_APPEND, -1, -2, -3, 0);
        issue(MODE_QUERY, rand_coord(), rand_coord(), rand_coord(), 1);
        issue(MODE_CLEAR, 0, 0, 0, 0);

        // Pause until everything issued has been answered.
        drain();

        // Random: mostly appends and queries on small tables, occasional clear and nop.
        for (int k = 0; k < 900; k++)
        begin
            m = $urandom_range(0, 99);
            if (m < 3)
                issue(MODE_CLEAR, rand_coord(), rand_coord(), rand_coord(), 1'($urandom));
            else if (m < 5)
                issue(MODE_UNUSED, rand_coord(), rand_coord(), rand_coord(), 1'($urandom));
            else if (m < 50)
                issue(MODE_APPEND, rand_coord(), rand_coord(), rand_coord(), 1'($urandom));
            else
                issue(MODE_QUERY, rand_coord(), rand_coord(), rand_coord(), 1'($urandom));
            if (k == 450)
                drain();
            sender_gap();
        end

        drain();
        repeat (300)
            @(posedge clk);
        $display("covered %0d appends and %0d queries incl. empty, full and tie cases",
                 n_append, n_query);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("timeout");
        $display("status: fail");
        $finish;
    end
endmodule

>>> files.f
+incdir+design
design/nplk_pkg.sv
design/nplk_front.sv
design/nplk_dist_pipe.sv
design/nplk_back.sv
design/nearest_point_lookup.sv
design/nplk_checker.sv
tb/sv/nearest_point_lookup_checker.sv
tb/sv/nearest_point_lookup_tb.sv
